// ----- rtl/core/strided_tensor_loop_address_generator_assert.svh -----
// Assertion macros shared by the checkers of this block.
// Each macro expects clk and rst in scope and is disabled during reset.
`ifndef STRIDED_TENSOR_LOOP_ADDRESS_GENERATOR_ASSERT_SVH
`define STRIDED_TENSOR_LOOP_ADDRESS_GENERATOR_ASSERT_SVH

// The consequence must hold in the same cycle as the antecedent.
`define STLAG_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("stlag check failed in the same cycle");

// The consequence must hold in the cycle after the antecedent.
`define STLAG_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("stlag check failed in the next cycle");

`endif

// ----- rtl/core/stlag_pkg.sv -----
`timescale 1ns / 1ps

package stlag_pkg;

  // Field widths of the words and registers.
  localparam int BOUND_W        = 16;
  localparam int STRIDE_W       = 24;
  localparam int OFFSET_W       = 32;
  localparam int TENSOR_COUNT_W = 3;
  localparam int SYMBOL_COUNT_W = 4;
  localparam int CFG_INDEX_W    = 2;
  localparam int CFG_DATA_W     = 4;

  // Command codes of an input word.
  localparam logic [2:0] CMD_WR_BOUND   = 3'd0;
  localparam logic [2:0] CMD_WR_STRIDE  = 3'd1;
  localparam logic [2:0] CMD_START      = 3'd2;
  localparam logic [2:0] CMD_STEP_OUTER = 3'd3;
  localparam logic [2:0] CMD_STEP_INNER = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_TENSOR_COUNT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SYMBOL_COUNT = 2'd1;

  typedef struct packed {
    logic [2:0]          command;
    logic [2:0]          symbol_sel;
    logic [1:0]          tensor_sel;
    logic [STRIDE_W-1:0] write_value;
  } item_t;

  typedef struct packed {
    logic [1:0]          tensor_id;
    logic [OFFSET_W-1:0] element_offset;
    logic                more;
    logic                last;
  } result_t;

  // Strobes from the controller to the datapath.
  typedef struct packed {
    logic wr_bound;
    logic wr_stride;
    logic start_clr;
    logic mark_load;
    logic idx_step;
    logic rd;
    logic mul;
    logic apply;
    logic add_mode;
    logic out_load;
    logic out_more;
    logic out_last;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mark_cur;
    logic wrap_cur;
    logic out_free;
  } ctrl_stat_t;

endpackage

// ----- rtl/core/stlag_ctrl.sv -----
`timescale 1ns / 1ps

module stlag_ctrl #(
  parameter int MAX_SYMBOLS = 8,
  parameter int MAX_TENSORS = 4
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      item_valid,
  output logic                                      item_stall,
  input  logic [2:0]                                command,
  input  logic                                      cfg_valid,
  output logic                                      cfg_ready,
  input  logic [stlag_pkg::CFG_INDEX_W-1:0]         cfg_index,
  input  logic [stlag_pkg::CFG_DATA_W-1:0]          cfg_data,
  output logic [$clog2(MAX_SYMBOLS+1)-1:0]          sym,
  output logic [$clog2(MAX_TENSORS)-1:0]            ten,
  output stlag_pkg::ctrl_cmd_t                      cmd,
  input  stlag_pkg::ctrl_stat_t                     stat
);

  localparam int SYM_CW = $clog2(MAX_SYMBOLS + 1);
  localparam int TEN_IW = $clog2(MAX_TENSORS);
  localparam int TEN_CW = $clog2(MAX_TENSORS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MARK_RD,
    ST_MARK_WR,
    ST_SCAN,
    ST_T_RD,
    ST_T_MUL,
    ST_T_APPLY,
    ST_EMIT
  } state_t;

  state_t                                   state;
  logic [stlag_pkg::TENSOR_COUNT_W-1:0]     tensor_count;
  logic [stlag_pkg::SYMBOL_COUNT_W-1:0]     symbol_count;
  logic                                     cls;
  logic                                     add_mode;
  logic                                     more;

  logic [TEN_CW-1:0] nt;
  logic [SYM_CW-1:0] ns;
  logic [TEN_IW-1:0] last_ten;
  logic [SYM_CW-1:0] sym_inc;
  logic              sym_end;
  logic              ten_last;
  logic              accept;

  // Counts clamped into the range the storage supports.
  always_comb begin
    if (tensor_count == '0) begin
      nt = TEN_CW'(1);
    end else if (int'(tensor_count) > MAX_TENSORS) begin
      nt = TEN_CW'(MAX_TENSORS);
    end else begin
      nt = TEN_CW'(tensor_count);
    end
    if (int'(symbol_count) > MAX_SYMBOLS) begin
      ns = SYM_CW'(MAX_SYMBOLS);
    end else begin
      ns = SYM_CW'(symbol_count);
    end
  end

  assign last_ten   = TEN_IW'(nt - TEN_CW'(1));
  assign sym_inc    = sym + SYM_CW'(1);
  assign sym_end    = (sym >= ns);
  assign ten_last   = (ten == last_ten);
  assign accept     = item_valid && (state == ST_IDLE);
  assign item_stall = (state != ST_IDLE);
  assign cfg_ready  = 1'b1;

  // Strobes to the datapath.
  always_comb begin
    cmd           = '0;
    cmd.wr_bound  = accept && (command == stlag_pkg::CMD_WR_BOUND);
    cmd.wr_stride = accept && (command == stlag_pkg::CMD_WR_STRIDE);
    cmd.start_clr = accept && (command == stlag_pkg::CMD_START);
    cmd.mark_load = (state == ST_MARK_WR);
    cmd.idx_step  = (state == ST_SCAN) && !sym_end && (stat.mark_cur == cls);
    cmd.rd        = (state == ST_MARK_RD) || (state == ST_T_RD);
    cmd.mul       = (state == ST_T_MUL);
    cmd.apply     = (state == ST_T_APPLY);
    cmd.add_mode  = add_mode;
    cmd.out_load  = (state == ST_EMIT) && stat.out_free;
    cmd.out_more  = more;
    cmd.out_last  = ten_last;
  end

  // Sequencer: mark pass after start, carry scan and per-tensor updates on a step.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      sym          <= '0;
      ten          <= '0;
      cls          <= 1'b0;
      add_mode     <= 1'b0;
      more         <= 1'b0;
      tensor_count <= stlag_pkg::TENSOR_COUNT_W'(1);
      symbol_count <= stlag_pkg::SYMBOL_COUNT_W'(1);
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          stlag_pkg::CFG_TENSOR_COUNT: tensor_count <= cfg_data[stlag_pkg::TENSOR_COUNT_W-1:0];
          stlag_pkg::CFG_SYMBOL_COUNT: symbol_count <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (command)
              stlag_pkg::CMD_START: begin
                sym   <= '0;
                ten   <= last_ten;
                state <= (ns == '0) ? ST_IDLE : ST_MARK_RD;
              end
              stlag_pkg::CMD_STEP_OUTER, stlag_pkg::CMD_STEP_INNER: begin
                cls   <= (command == stlag_pkg::CMD_STEP_INNER);
                sym   <= '0;
                more  <= 1'b0;
                state <= ST_SCAN;
              end
              default: ;
            endcase
          end
        end
        ST_MARK_RD: begin
          state <= ST_MARK_WR;
        end
        ST_MARK_WR: begin
          sym   <= sym_inc;
          state <= (sym_inc >= ns) ? ST_IDLE : ST_MARK_RD;
        end
        ST_SCAN: begin
          if (sym_end) begin
            ten   <= '0;
            state <= ST_EMIT;
          end else if (stat.mark_cur != cls) begin
            sym <= sym_inc;
          end else begin
            add_mode <= !stat.wrap_cur;
            ten      <= '0;
            state    <= ST_T_RD;
          end
        end
        ST_T_RD: begin
          state <= ST_T_MUL;
        end
        ST_T_MUL: begin
          state <= ST_T_APPLY;
        end
        ST_T_APPLY: begin
          if (ten_last) begin
            ten <= '0;
            if (add_mode) begin
              more  <= 1'b1;
              state <= ST_EMIT;
            end else begin
              sym   <= sym_inc;
              state <= ST_SCAN;
            end
          end else begin
            ten   <= ten + TEN_IW'(1);
            state <= ST_T_RD;
          end
        end
        ST_EMIT: begin
          if (stat.out_free) begin
            if (ten_last) begin
              ten   <= '0;
              state <= ST_IDLE;
            end else begin
              ten <= ten + TEN_IW'(1);
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/stlag_datapath.sv -----
`timescale 1ns / 1ps

module stlag_datapath #(
  parameter int MAX_SYMBOLS = 8,
  parameter int MAX_TENSORS = 4
) (
  input  logic                               clk,
  input  logic                               rst,
  input  stlag_pkg::item_t                   item,
  input  logic [$clog2(MAX_SYMBOLS+1)-1:0]   sym,
  input  logic [$clog2(MAX_TENSORS)-1:0]     ten,
  input  stlag_pkg::ctrl_cmd_t               cmd,
  output stlag_pkg::ctrl_stat_t              stat,
  output logic                               result_valid,
  input  logic                               result_stall,
  output stlag_pkg::result_t                 result
);

  localparam int SYM_IW  = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int DEPTH   = MAX_TENSORS * MAX_SYMBOLS;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int BW      = stlag_pkg::BOUND_W;
  localparam int SW      = stlag_pkg::STRIDE_W;
  localparam int OW      = stlag_pkg::OFFSET_W;

  logic [BW-1:0]      loop_bound    [MAX_SYMBOLS];
  logic [BW-1:0]      loop_index    [MAX_SYMBOLS];
  logic [MAX_SYMBOLS-1:0] inner_mark;
  logic [OW-1:0]      tensor_offset [MAX_TENSORS];
  logic [SW-1:0]      stride_mem    [DEPTH];
  logic [DEPTH-1:0]   stride_ok;
  logic [SW-1:0]      rd_data;
  logic               rd_ok;
  logic [OW-1:0]      prod;

  logic [SYM_IW-1:0]  sym_i;
  logic [BW-1:0]      cur_bound;
  logic [BW-1:0]      cur_index;
  logic               wrap_cur;
  logic [ADDR_W-1:0]  rd_addr;
  logic [ADDR_W-1:0]  wr_addr;
  logic               stride_wr_ok;
  logic               bound_wr_ok;
  logic [SYM_IW-1:0]  wr_sym;
  logic [BW-1:0]      bound_val;
  logic [SW-1:0]      stride_val;
  logic [BW-1:0]      factor;
  logic [BW+SW-1:0]   prod_full;

  assign sym_i     = SYM_IW'(sym);
  assign cur_bound = loop_bound[sym_i];
  assign cur_index = loop_index[sym_i];
  // A counter at or past its bound minus one wraps on the next increment.
  assign wrap_cur  = ({1'b0, cur_index} + (BW+1)'(1)) >= {1'b0, cur_bound};

  assign rd_addr      = ADDR_W'(int'(ten) * MAX_SYMBOLS + int'(sym_i));
  assign wr_addr      = ADDR_W'(int'(item.tensor_sel) * MAX_SYMBOLS + int'(item.symbol_sel));
  assign bound_wr_ok  = int'(item.symbol_sel) < MAX_SYMBOLS;
  assign stride_wr_ok = bound_wr_ok && (int'(item.tensor_sel) < MAX_TENSORS);
  assign wr_sym       = SYM_IW'(item.symbol_sel);

  // Written bounds saturate high and never go below one.
  always_comb begin
    if (item.write_value > SW'(16'hFFFF)) begin
      bound_val = 16'hFFFF;
    end else if (item.write_value == '0) begin
      bound_val = BW'(1);
    end else begin
      bound_val = item.write_value[BW-1:0];
    end
  end

  // Entries never written read as zero.
  assign stride_val = rd_ok ? rd_data : '0;
  // An advance adds the stride once; a wrap takes back (bound-1) strides.
  assign factor     = cmd.add_mode ? BW'(1) : (cur_bound - BW'(1));
  assign prod_full  = (BW+SW)'(factor) * (BW+SW)'(stride_val);

  assign stat.mark_cur = inner_mark[sym_i];
  assign stat.wrap_cur = wrap_cur;
  assign stat.out_free = !result_valid || !result_stall;

  // Stride memory with a registered read port.
  always_ff @(posedge clk) begin
    if (cmd.wr_stride && stride_wr_ok) begin
      stride_mem[wr_addr] <= item.write_value;
    end
    if (cmd.rd) begin
      rd_data <= stride_mem[rd_addr];
    end
  end

  // Product register between the multiplier and the offset adders.
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod <= prod_full[OW-1:0];
    end
  end

  // Loop state, offsets and stride valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      stride_ok  <= '0;
      rd_ok      <= 1'b0;
      inner_mark <= '0;
      for (int i = 0; i < MAX_SYMBOLS; i++) begin
        loop_bound[i] <= BW'(1);
        loop_index[i] <= '0;
      end
      for (int j = 0; j < MAX_TENSORS; j++) begin
        tensor_offset[j] <= '0;
      end
    end else begin
      if (cmd.wr_stride && stride_wr_ok) begin
        stride_ok[wr_addr] <= 1'b1;
      end
      if (cmd.rd) begin
        rd_ok <= stride_ok[rd_addr];
      end
      if (cmd.wr_bound && bound_wr_ok) begin
        loop_bound[wr_sym] <= bound_val;
      end
      if (cmd.start_clr) begin
        inner_mark <= '0;
        for (int i = 0; i < MAX_SYMBOLS; i++) begin
          loop_index[i] <= '0;
        end
        for (int j = 0; j < MAX_TENSORS; j++) begin
          tensor_offset[j] <= '0;
        end
      end
      if (cmd.mark_load) begin
        inner_mark[sym_i] <= (stride_val == '0);
      end
      if (cmd.idx_step) begin
        loop_index[sym_i] <= wrap_cur ? '0 : (cur_index + BW'(1));
      end
      if (cmd.apply) begin
        if (cmd.add_mode) begin
          tensor_offset[ten] <= tensor_offset[ten] + prod;
        end else begin
          tensor_offset[ten] <= tensor_offset[ten] - prod;
        end
      end
    end
  end

  // Output register: loaded when empty or when its word is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result.tensor_id      <= 2'(ten);
      result.element_offset <= tensor_offset[ten];
      result.more           <= cmd.out_more;
      result.last           <= cmd.out_last;
    end
  end

endmodule

// ----- rtl/core/strided_tensor_loop_address_generator.sv -----
// Bound and stride writes leave the block idle, so the next word is accepted right after.
// Start runs a mark pass over the S symbols in use: one stride memory read per inner mark.
// Step: accept, then look at the symbols in turn (once more when the class runs out),
// read, multiply and apply for each of T tensors per symbol advanced or rewound,
// then hand out the T result words, waiting while the output is stalled.
// Reset is synchronous: bounds one, strides, counters, marks and offsets zero, counts 1.
`timescale 1ns / 1ps

module strided_tensor_loop_address_generator #(
  parameter int MAX_SYMBOLS = 8,
  parameter int MAX_TENSORS = 4
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 item_valid,
  output logic                                 item_stall,
  input  stlag_pkg::item_t                     item,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output stlag_pkg::result_t                   result,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [stlag_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [stlag_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int SYM_CW = $clog2(MAX_SYMBOLS + 1);
  localparam int TEN_IW = $clog2(MAX_TENSORS);

  logic [SYM_CW-1:0]      sym;
  logic [TEN_IW-1:0]      ten;
  stlag_pkg::ctrl_cmd_t   cmd;
  stlag_pkg::ctrl_stat_t  stat;

  // Sequencer and configuration registers.
  stlag_ctrl #(
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .MAX_TENSORS (MAX_TENSORS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .command    (item.command),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .sym        (sym),
    .ten        (ten),
    .cmd        (cmd),
    .stat       (stat)
  );

  // Tables, offsets, multiplier and output register.
  stlag_datapath #(
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .MAX_TENSORS (MAX_TENSORS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .sym          (sym),
    .ten          (ten),
    .cmd          (cmd),
    .stat         (stat),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// ----- rtl/core/stlag_checker.sv -----
`timescale 1ns / 1ps
`include "strided_tensor_loop_address_generator_assert.svh"

module stlag_checker (
  input logic                clk,
  input logic                rst,
  input logic                item_valid,
  input logic                item_stall,
  input stlag_pkg::item_t    item,
  input logic                result_valid,
  input logic                result_stall,
  input stlag_pkg::result_t  result,
  input logic                cfg_valid,
  input logic                cfg_ready
);

  // A stalled result word holds.
  `STLAG_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result))

  // A step keeps the input side busy in the following cycle.
  `STLAG_NEXT(a_step_busy, item_valid && !item_stall && (item.command == stlag_pkg::CMD_STEP_OUTER || item.command == stlag_pkg::CMD_STEP_INNER), item_stall)

  // Table writes finish at once and the next word can follow.
  `STLAG_NEXT(a_write_free, item_valid && !item_stall && (item.command == stlag_pkg::CMD_WR_BOUND || item.command == stlag_pkg::CMD_WR_STRIDE), !item_stall)

  // Words of one step follow each other without gaps, in tensor order.
  `STLAG_NEXT(a_burst, result_valid && !result_stall && !result.last, result_valid && (result.tensor_id == $past(result.tensor_id) + 2'd1))

  // Configuration writes are never held off.
  `STLAG_IMPLIES(a_cfg_ready, cfg_valid, cfg_ready)

endmodule

bind strided_tensor_loop_address_generator stlag_checker u_stlag_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .item         (item),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result),
  .cfg_valid    (cfg_valid),
  .cfg_ready    (cfg_ready)
);
